>>> rtl/bba_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// bba_pkg
// Shared types, codes and helpers for the buddy block allocator.
// ============================================================================
package bba_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_BLOCKS_DEF = 256;
    localparam int MAX_ORDER_DEF  = 24;

    // Fixed field widths
    localparam int ORD_W      = 5;
    localparam int REQ_W      = 2;
    localparam int SIZE_W     = 25;
    localparam int OFFS_W     = 24;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Register reset values
    localparam logic [ORD_W-1:0] TOTAL_ORDER_RST = 5'd16;
    localparam logic [ORD_W-1:0] MIN_ORDER_RST   = 5'd8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_ORDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ORDER   = 2'd1;

    // One list entry: allocated mark and order
    typedef struct packed {
        logic             used;
        logic [ORD_W-1:0] ord;
    } entry_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_FREE    = 2'd1,
        REQ_REALLOC = 2'd2,
        REQ_REINIT  = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_SPACE  = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

    // Stack operations
    typedef enum logic [2:0] {
        SOP_HOLD  = 3'd0,
        SOP_PUSH  = 3'd1,   // din onto top, rest shift down
        SOP_POP   = 3'd2,   // rest shift up
        SOP_WRITE = 3'd3,   // replace top with din
        SOP_DROP2 = 3'd4    // replace top with din, remove second
    } sop_t;

    typedef struct packed {
        sop_t   op;
        entry_t din;
        logic   save;
        logic   restore;
    } bba_stack_ctl_t;

    typedef struct packed {
        logic from_prev;
        logic from_next;
        logic save;
        logic restore;
    } bba_cell_ctl_t;

    // Smallest r with 2^r >= v (zero for v of zero or one)
    function automatic logic [ORD_W-1:0] ceil_log2(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] m;
        logic [ORD_W-1:0]  r;
        m = v - SIZE_W'(1);
        r = '0;
        if (v > SIZE_W'(1))
        begin
            for (int i = 0; i < SIZE_W; i++)
            begin
                if (m[i])
                    r = ORD_W'(i + 1);
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/bba_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// bba_cell
// One stack cell: a list entry plus its snapshot copy.
// ============================================================================
module bba_cell (
    input  logic                   clk,
    input  bba_pkg::bba_cell_ctl_t ctl,
    input  bba_pkg::entry_t        prev,
    input  bba_pkg::entry_t        next,
    output bba_pkg::entry_t        value
);
    import bba_pkg::*;

    entry_t entry_reg;
    entry_t saved_reg;

    // entry moves with the stack or comes back from the snapshot
    always_ff @(posedge clk)
    begin
        if (ctl.restore)
            entry_reg <= saved_reg;
        else if (ctl.from_prev)
            entry_reg <= prev;
        else if (ctl.from_next)
            entry_reg <= next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.save)
            saved_reg <= entry_reg;
    end

    assign value = entry_reg;

endmodule

>>> rtl/bba_stack.sv
`timescale 1ns / 1ps
// ============================================================================
// bba_stack
// Chain of cells used as a stack; top is cell zero.
// ============================================================================
module bba_stack #(
    parameter int DEPTH = bba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                    clk,
    input  bba_pkg::bba_stack_ctl_t ctl,
    output bba_pkg::entry_t         top,
    output bba_pkg::entry_t         second
);
    import bba_pkg::*;

    entry_t ent [DEPTH];

    genvar j;
    generate
        for (j = 0; j < DEPTH; j++)
        begin : g_cell
            bba_cell_ctl_t cctl;
            entry_t        prev_v;
            entry_t        next_v;

            // per-cell decode of the stack operation
            always_comb
            begin
                cctl.save      = ctl.save;
                cctl.restore   = ctl.restore;
                cctl.from_prev = 1'b0;
                cctl.from_next = 1'b0;
                unique case (ctl.op)
                    SOP_PUSH:  cctl.from_prev = 1'b1;
                    SOP_POP:   cctl.from_next = 1'b1;
                    SOP_WRITE: cctl.from_prev = (j == 0);
                    SOP_DROP2:
                    begin
                        cctl.from_prev = (j == 0);
                        cctl.from_next = (j != 0);
                    end
                    default:   cctl.from_prev = 1'b0;
                endcase
            end

            if (j == 0)
            begin : g_first
                assign prev_v = ctl.din;
            end
            else
            begin : g_mid
                assign prev_v = ent[j-1];
            end

            if (j == DEPTH - 1)
            begin : g_last
                assign next_v = '0;
            end
            else
            begin : g_inner
                assign next_v = ent[j+1];
            end

            bba_cell u_cell (
                .clk   (clk),
                .ctl   (cctl),
                .prev  (prev_v),
                .next  (next_v),
                .value (ent[j])
            );
        end
    endgenerate

    assign top    = ent[0];
    assign second = ent[1];

endmodule

>>> rtl/buddy_block_allocator.sv
`timescale 1ns / 1ps
// ============================================================================
// buddy_block_allocator
// Buddy allocator keeping an address-ordered block list in two cell stacks.
// ============================================================================
// The block list sits in two chains of cells that form a cursor: entries left
// of the cursor in one stack, the rest in the other, and the cursor moves one
// entry per cycle. Every request but a reinit first walks the cursor back to
// the start and then forward until it finds its block or reaches the end of
// the list, then splits a larger block or merges free buddies where needed.
// A realloc of nonzero size runs a free and an alloc back to back. One
// request is worked on at a time; the next is taken while the previous
// result waits in the output register. After reset the block sets up its
// list in S_INIT before it takes a request.
module buddy_block_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
    parameter int MAX_ORDER  = bba_pkg::MAX_ORDER_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [bba_pkg::REQ_W-1:0]        req_type,
    input  logic [bba_pkg::SIZE_W-1:0]       request_bytes,
    input  logic [bba_pkg::OFFS_W-1:0]       block_offset,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [bba_pkg::STAT_W-1:0]       status,
    output logic [bba_pkg::OFFS_W-1:0]       result_offset,
    output logic [bba_pkg::ORD_W-1:0]        granted_order
);
    import bba_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int OFF_W = MAX_ORDER + 1;
    localparam int NEED_W = CNT_W + 6;

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_REWIND = 8'b0000_0100,
        S_SCAN   = 8'b0000_1000,
        S_SEEK   = 8'b0001_0000,
        S_SPLIT  = 8'b0010_0000,
        S_MERGE  = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } state_t;

    // control state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] lcnt_reg, lcnt_next;
    logic [CNT_W-1:0] rcnt_reg, rcnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [ORD_W-1:0] total_order_reg, min_order_reg;

    // working registers
    logic             alloc_phase_reg, alloc_phase_next;
    logic             realloc_reg, realloc_next;
    logic [ORD_W-1:0] o_reg, o_next;
    logic [OFFS_W-1:0] target_reg, target_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic             best_found_reg, best_found_next;
    logic [ORD_W-1:0] best_ord_reg, best_ord_next;
    logic [CNT_W-1:0] best_idx_reg, best_idx_next;
    logic [ORD_W-1:0] cur_ord_reg, cur_ord_next;
    logic [CNT_W-1:0] sv_lcnt_reg, sv_lcnt_next;
    logic [CNT_W-1:0] sv_rcnt_reg, sv_rcnt_next;
    logic [OFF_W-1:0] sv_off_reg, sv_off_next;
    status_t          res_status_reg, res_status_next;
    logic [OFFS_W-1:0] res_off_reg, res_off_next;
    logic [ORD_W-1:0] res_ord_reg, res_ord_next;
    logic [STAT_W-1:0] out_status_reg;
    logic [OFFS_W-1:0] out_off_reg;
    logic [ORD_W-1:0] out_ord_reg;

    bba_stack_ctl_t lctl, rctl;
    entry_t         top_l, top_r, sec_r, sec_l;

    logic [ORD_W-1:0]  clamp_ord;
    logic [ORD_W-1:0]  req_clog;
    logic [ORD_W-1:0]  o_calc;
    logic [31:0]       off_ext;
    logic [ORD_W-1:0]  k;
    logic [NEED_W-1:0] need;
    logic              out_load;

    // list stacks: left holds entries before the cursor, right the rest
    bba_stack #(.DEPTH(MAX_BLOCKS)) u_left (
        .clk    (clk),
        .ctl    (lctl),
        .top    (top_l),
        .second (sec_l)
    );

    bba_stack #(.DEPTH(MAX_BLOCKS)) u_right (
        .clk    (clk),
        .ctl    (rctl),
        .top    (top_r),
        .second (sec_r)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_order_reg <= TOTAL_ORDER_RST;
            min_order_reg   <= MIN_ORDER_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_TOTAL_ORDER)
                total_order_reg <= cfg_data;
            else if (cfg_index == CFG_MIN_ORDER)
                min_order_reg <= cfg_data;
        end
    end

    // helpers
    assign clamp_ord = (32'(total_order_reg) > 32'(MAX_ORDER)) ?
                       ORD_W'(MAX_ORDER) : total_order_reg;
    assign req_clog  = ceil_log2(request_bytes);
    assign o_calc    = (req_clog > min_order_reg) ? req_clog : min_order_reg;
    assign off_ext   = 32'(off_reg);
    assign k         = top_r.ord;
    assign need      = NEED_W'(lcnt_reg) + NEED_W'(rcnt_reg)
                     + NEED_W'(best_ord_reg - o_reg);
    assign out_load  = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);
    assign in_stall  = (state_reg != S_IDLE);

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        lcnt_next        = lcnt_reg;
        rcnt_next        = rcnt_reg;
        alloc_phase_next = alloc_phase_reg;
        realloc_next     = realloc_reg;
        o_next           = o_reg;
        target_next      = target_reg;
        off_next         = off_reg;
        best_found_next  = best_found_reg;
        best_ord_next    = best_ord_reg;
        best_idx_next    = best_idx_reg;
        cur_ord_next     = cur_ord_reg;
        sv_lcnt_next     = sv_lcnt_reg;
        sv_rcnt_next     = sv_rcnt_reg;
        sv_off_next      = sv_off_reg;
        res_status_next  = res_status_reg;
        res_off_next     = res_off_reg;
        res_ord_next     = res_ord_reg;
        lctl             = '{op: SOP_HOLD, din: '0, save: 1'b0, restore: 1'b0};
        rctl             = '{op: SOP_HOLD, din: '0, save: 1'b0, restore: 1'b0};

        unique case (state_reg)
            S_INIT:
            begin
                lcnt_next  = '0;
                rcnt_next  = CNT_W'(1);
                off_next   = '0;
                rctl.op    = SOP_WRITE;
                rctl.din   = '{used: 1'b0, ord: clamp_ord};
                state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    target_next      = block_offset;
                    o_next           = o_calc;
                    realloc_next     = 1'b0;
                    alloc_phase_next = 1'b0;
                    res_status_next  = STAT_OK;
                    res_off_next     = '0;
                    res_ord_next     = '0;
                    state_next       = S_REWIND;
                    unique case (req_t'(req_type))
                        REQ_REINIT:
                        begin
                            lcnt_next  = '0;
                            rcnt_next  = CNT_W'(1);
                            off_next   = '0;
                            rctl.op    = SOP_WRITE;
                            rctl.din   = '{used: 1'b0, ord: clamp_ord};
                            state_next = S_FINISH;
                        end
                        REQ_ALLOC:
                            alloc_phase_next = 1'b1;
                        REQ_FREE:
                            alloc_phase_next = 1'b0;
                        REQ_REALLOC:
                        begin
                            if (request_bytes != '0)
                            begin
                                realloc_next = 1'b1;
                                lctl.save    = 1'b1;
                                rctl.save    = 1'b1;
                                sv_lcnt_next = lcnt_reg;
                                sv_rcnt_next = rcnt_reg;
                                sv_off_next  = off_reg;
                            end
                        end
                        default:
                            alloc_phase_next = 1'b0;
                    endcase
                end
            end

            // move the cursor back to the start of the list
            S_REWIND:
            begin
                if (lcnt_reg == '0)
                begin
                    best_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
                else
                begin
                    lctl.op   = SOP_POP;
                    rctl.op   = SOP_PUSH;
                    rctl.din  = top_l;
                    lcnt_next = lcnt_reg - CNT_W'(1);
                    rcnt_next = rcnt_reg + CNT_W'(1);
                    off_next  = off_reg - (OFF_W'(1) << top_l.ord);
                end
            end

            // walk forward looking at the entry right of the cursor
            S_SCAN:
            begin
                if (rcnt_reg == '0)
                begin
                    if (!alloc_phase_reg)
                    begin
                        if (realloc_reg)
                        begin
                            alloc_phase_next = 1'b1;
                            state_next       = S_REWIND;
                        end
                        else
                        begin
                            res_status_next = STAT_NOT_FOUND;
                            state_next      = S_FINISH;
                        end
                    end
                    else if (best_found_reg)
                        state_next = S_SEEK;
                    else
                    begin
                        res_status_next = STAT_NO_SPACE;
                        if (realloc_reg)
                        begin
                            lctl.restore = 1'b1;
                            rctl.restore = 1'b1;
                            lcnt_next    = sv_lcnt_reg;
                            rcnt_next    = sv_rcnt_reg;
                            off_next     = sv_off_reg;
                        end
                        state_next = S_FINISH;
                    end
                end
                else if (!alloc_phase_reg && top_r.used
                         && (off_ext == 32'(target_reg)))
                begin
                    rctl.op    = SOP_WRITE;
                    rctl.din   = '{used: 1'b0, ord: top_r.ord};
                    state_next = S_MERGE;
                end
                else if (alloc_phase_reg && !top_r.used && (top_r.ord == o_reg))
                begin
                    rctl.op         = SOP_WRITE;
                    rctl.din        = '{used: 1'b1, ord: o_reg};
                    res_status_next = STAT_OK;
                    res_off_next    = OFFS_W'(off_reg);
                    res_ord_next    = o_reg;
                    state_next      = S_FINISH;
                end
                else
                begin
                    // remember leftmost free block of the smallest larger order
                    if (alloc_phase_reg && !top_r.used && (top_r.ord > o_reg)
                        && (!best_found_reg || (top_r.ord < best_ord_reg)))
                    begin
                        best_found_next = 1'b1;
                        best_ord_next   = top_r.ord;
                        best_idx_next   = lcnt_reg;
                    end
                    lctl.op   = SOP_PUSH;
                    lctl.din  = top_r;
                    rctl.op   = SOP_POP;
                    lcnt_next = lcnt_reg + CNT_W'(1);
                    rcnt_next = rcnt_reg - CNT_W'(1);
                    off_next  = off_reg + (OFF_W'(1) << top_r.ord);
                end
            end

            // walk back to the block chosen for splitting
            S_SEEK:
            begin
                if (lcnt_reg == best_idx_reg)
                begin
                    if (need > NEED_W'(MAX_BLOCKS))
                    begin
                        res_status_next = STAT_NO_SPACE;
                        if (realloc_reg)
                        begin
                            lctl.restore = 1'b1;
                            rctl.restore = 1'b1;
                            lcnt_next    = sv_lcnt_reg;
                            rcnt_next    = sv_rcnt_reg;
                            off_next     = sv_off_reg;
                        end
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        rctl.op      = SOP_WRITE;
                        rctl.din     = '{used: 1'b0, ord: best_ord_reg - ORD_W'(1)};
                        cur_ord_next = best_ord_reg - ORD_W'(1);
                        state_next   = S_SPLIT;
                    end
                end
                else
                begin
                    lctl.op   = SOP_POP;
                    rctl.op   = SOP_PUSH;
                    rctl.din  = top_l;
                    lcnt_next = lcnt_reg - CNT_W'(1);
                    rcnt_next = rcnt_reg + CNT_W'(1);
                    off_next  = off_reg - (OFF_W'(1) << top_l.ord);
                end
            end

            // push the split halves, largest first, then the granted block
            S_SPLIT:
            begin
                rctl.op   = SOP_PUSH;
                rcnt_next = rcnt_reg + CNT_W'(1);
                if (cur_ord_reg == o_reg)
                begin
                    rctl.din        = '{used: 1'b1, ord: o_reg};
                    res_status_next = STAT_OK;
                    res_off_next    = OFFS_W'(off_reg);
                    res_ord_next    = o_reg;
                    state_next      = S_FINISH;
                end
                else
                begin
                    rctl.din     = '{used: 1'b0, ord: cur_ord_reg - ORD_W'(1)};
                    cur_ord_next = cur_ord_reg - ORD_W'(1);
                end
            end

            // merge the freed block with free buddies, one per cycle
            S_MERGE:
            begin
                if ((k != '1) && !off_ext[k] && (rcnt_reg >= CNT_W'(2))
                    && !sec_r.used && (sec_r.ord == k))
                begin
                    rctl.op   = SOP_DROP2;
                    rctl.din  = '{used: 1'b0, ord: k + ORD_W'(1)};
                    rcnt_next = rcnt_reg - CNT_W'(1);
                end
                else if ((k != '1) && off_ext[k] && (lcnt_reg != '0)
                         && !top_l.used && (top_l.ord == k))
                begin
                    lctl.op   = SOP_POP;
                    rctl.op   = SOP_WRITE;
                    rctl.din  = '{used: 1'b0, ord: k + ORD_W'(1)};
                    lcnt_next = lcnt_reg - CNT_W'(1);
                    off_next  = off_reg - (OFF_W'(1) << k);
                end
                else if (realloc_reg)
                begin
                    alloc_phase_next = 1'b1;
                    state_next       = S_REWIND;
                end
                else
                begin
                    res_status_next = STAT_OK;
                    state_next      = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_INIT;
        endcase
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            lcnt_reg      <= '0;
            rcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lcnt_reg      <= lcnt_next;
            rcnt_reg      <= rcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        alloc_phase_reg <= alloc_phase_next;
        realloc_reg     <= realloc_next;
        o_reg           <= o_next;
        target_reg      <= target_next;
        off_reg         <= off_next;
        best_found_reg  <= best_found_next;
        best_ord_reg    <= best_ord_next;
        best_idx_reg    <= best_idx_next;
        cur_ord_reg     <= cur_ord_next;
        sv_lcnt_reg     <= sv_lcnt_next;
        sv_rcnt_reg     <= sv_rcnt_next;
        sv_off_reg      <= sv_off_next;
        res_status_reg  <= res_status_next;
        res_off_reg     <= res_off_next;
        res_ord_reg     <= res_ord_next;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_off_reg    <= res_off_reg;
            out_ord_reg    <= res_ord_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign result_offset = out_off_reg;
    assign granted_order = out_ord_reg;

endmodule

>>> sim/tb_buddy_block_allocator.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_buddy_block_allocator
// Self-checking testbench for the buddy block allocator.
// ============================================================================
// A directed table is run first against hand-worked results. Random allocs,
// frees, reallocs and reinits then run over several heap and block-size
// settings. A behavioral copy of the block list predicts every random result.
// Each result transfer is compared field by field with the oldest prediction.
// Both sides stall at random, the mix changing by phase; the last three phases have none.
// ============================================================================
module tb_buddy_block_allocator;
    import bba_pkg::*;

    localparam int NBLK = MAX_BLOCKS_DEF;
    localparam int MORD = MAX_ORDER_DEF;
    localparam int RAND_PER_PHASE = 165;
    localparam int NPHASE = 7;

    typedef struct packed {
        status_t          st;
        logic [OFFS_W-1:0] offs;
        logic [ORD_W-1:0]  ord;
    } grant_t;

    typedef struct {
        req_t              req;
        logic [SIZE_W-1:0] bytes;
        logic [OFFS_W-1:0] offs;
        grant_t            want;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [REQ_W-1:0]      req_type;
    logic [SIZE_W-1:0]     request_bytes;
    logic [OFFS_W-1:0]     block_offset;
    logic                  out_valid;
    logic                  out_stall;
    logic [STAT_W-1:0]     status;
    logic [OFFS_W-1:0]     result_offset;
    logic [ORD_W-1:0]      granted_order;

    // Predictor state: block list, its backup for realloc, and the registers
    entry_t     blist [NBLK];
    entry_t     saved [NBLK];
    int         bcount;
    logic [4:0] heap_order_reg;
    logic [4:0] min_order_reg;

    grant_t grant_q[$];
    int     err_count;
    int     grant_count;
    int     tx_idle_pct;
    int     rx_idle_pct;

    buddy_block_allocator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .request_bytes (request_bytes),
        .block_offset  (block_offset),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .result_offset (result_offset),
        .granted_order (granted_order)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Rebuild the list as one free block of the heap order
    function automatic void heap_rebuild();
        int t;
        t = (heap_order_reg > MORD) ? MORD : heap_order_reg;
        foreach (blist[j])
            blist[j] = '0;
        blist[0].ord = t[4:0];
        bcount = 1;
    endfunction

    // First fit of the exact order, else split the smallest larger free block
    function automatic bit heap_alloc(longint size, output longint off, output int ord);
        int     o;
        longint pos;
        o = min_order_reg;
        off = 0;
        ord = 0;
        while (o < 31 && (longint'(1) << o) < size)
            o++;
        if ((longint'(1) << o) < size)
            return 1'b0;
        pos = 0;
        for (int i = 0; i < bcount; i++)
        begin
            if (!blist[i].used && blist[i].ord == o)
            begin
                blist[i].used = 1'b1;
                off = pos;
                ord = o;
                return 1'b1;
            end
            pos += longint'(1) << blist[i].ord;
        end
        for (int n = 1; o + n <= 31; n++)
        begin
            pos = 0;
            for (int i = 0; i < bcount; i++)
            begin
                if (!blist[i].used && blist[i].ord == o + n)
                begin
                    if (bcount + n > NBLK)
                        return 1'b0;
                    for (int j = bcount - 1; j > i; j--)
                        blist[j + n] = blist[j];
                    blist[i].used = 1'b1;
                    blist[i].ord  = o[4:0];
                    for (int c = 0; c < n; c++)
                    begin
                        blist[i + 1 + c].used = 1'b0;
                        blist[i + 1 + c].ord  = 5'(o + c);
                    end
                    bcount += n;
                    off = pos;
                    ord = o;
                    return 1'b1;
                end
                pos += longint'(1) << blist[i].ord;
            end
        end
        return 1'b0;
    endfunction

    function automatic void heap_remove(int i);
        for (int j = i; j < bcount - 1; j++)
            blist[j] = blist[j + 1];
        bcount--;
    endfunction

    // Release the block at an offset and merge free buddies upward
    function automatic status_t heap_free(longint target);
        int     i;
        int     k;
        longint pos;
        pos = 0;
        for (i = 0; i < bcount; i++)
        begin
            if (pos == target && blist[i].used)
                break;
            pos += longint'(1) << blist[i].ord;
        end
        if (i >= bcount)
            return STAT_NOT_FOUND;
        blist[i].used = 1'b0;
        forever
        begin
            k = blist[i].ord;
            if (k >= 31)
                break;
            if (((pos >> k) & 1) == 0)
            begin
                if (i + 1 < bcount && !blist[i + 1].used && blist[i + 1].ord == k)
                begin
                    blist[i].ord = 5'(k + 1);
                    heap_remove(i + 1);
                end
                else
                    break;
            end
            else
            begin
                if (i > 0 && !blist[i - 1].used && blist[i - 1].ord == k)
                begin
                    blist[i - 1].ord = 5'(k + 1);
                    heap_remove(i);
                    i--;
                    pos -= longint'(1) << k;
                end
                else
                    break;
            end
        end
        return STAT_OK;
    endfunction

    // Apply one request to the predicted heap and return its grant
    function automatic grant_t heap_request(req_t req, logic [SIZE_W-1:0] bytes,
                                            logic [OFFS_W-1:0] where);
        grant_t g;
        longint off;
        int     ord;
        int     kept;
        g = '0;
        case (req)
            REQ_ALLOC:
            begin
                if (heap_alloc(bytes, off, ord))
                begin
                    g.offs = off[OFFS_W-1:0];
                    g.ord  = ord[ORD_W-1:0];
                end
                else
                    g.st = STAT_NO_SPACE;
            end
            REQ_FREE:
                g.st = heap_free(where);
            REQ_REALLOC:
            begin
                if (bytes == '0)
                    g.st = heap_free(where);
                else
                begin
                    kept = bcount;
                    saved = blist;
                    void'(heap_free(where));
                    if (heap_alloc(bytes, off, ord))
                    begin
                        g.offs = off[OFFS_W-1:0];
                        g.ord  = ord[ORD_W-1:0];
                    end
                    else
                    begin
                        blist = saved;
                        bcount = kept;
                        g.st = STAT_NO_SPACE;
                    end
                end
            end
            default:
                heap_rebuild();
        endcase
        return g;
    endfunction

    // Offset of a random allocated block, or a random offset if none
    function automatic logic [OFFS_W-1:0] pick_used_offset();
        longint pos;
        int     nused;
        int     pick;
        nused = 0;
        for (int i = 0; i < bcount; i++)
            if (blist[i].used)
                nused++;
        if (nused == 0)
            return OFFS_W'($urandom);
        pick = $urandom_range(0, nused - 1);
        pos = 0;
        for (int i = 0; i < bcount; i++)
        begin
            if (blist[i].used)
            begin
                if (pick == 0)
                    return pos[OFFS_W-1:0];
                pick--;
            end
            pos += longint'(1) << blist[i].ord;
        end
        return '0;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        grant_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (grant_q.size() == 0)
                report_mismatch("unexpected result transfer", 1, 0);
            else
            begin
                w = grant_q.pop_front();
                grant_count++;
                if (status !== w.st)
                    report_mismatch("status", status, w.st);
                if (result_offset !== w.offs)
                    report_mismatch("result_offset", result_offset, w.offs);
                if (granted_order !== w.ord)
                    report_mismatch("granted_order", granted_order, w.ord);
            end
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // One request transfer, with random sender gaps before it
    task automatic send_request(req_t req, logic [SIZE_W-1:0] bytes,
                                logic [OFFS_W-1:0] where, bit typed, grant_t want);
        grant_t g;
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= req;
        request_bytes <= bytes;
        block_offset  <= where;
        do
            @(posedge clk);
        while (in_stall);
        g = heap_request(req, bytes, where);
        grant_q.push_back(typed ? want : g);
    endtask

    // Hold off the sender until every predicted result has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_TOTAL_ORDER)
            heap_order_reg = val;
        else if (idx == CFG_MIN_ORDER)
            min_order_reg = val;
    endtask

    // Random size, mostly near the block sizes that fit the heap
    function automatic logic [SIZE_W-1:0] rand_size();
        int r;
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return SIZE_W'($urandom);
            2:       return 25'd16777216;
            default:
            begin
                r = $urandom_range(0, (heap_order_reg > MORD ? MORD : heap_order_reg));
                return SIZE_W'(($urandom & ((32'd1 << r) - 1)) + 1);
            end
        endcase
    endfunction

    // Directed table, worked by hand for the reset settings
    dir_row_t dir_tab[] = '{
        '{REQ_ALLOC,   25'd1,        24'd0,        '{STAT_OK,        24'd0,   5'd8}},
        '{REQ_ALLOC,   25'd0,        24'd0,        '{STAT_OK,        24'd256, 5'd8}},
        '{REQ_FREE,    25'd0,        24'd0,        '{STAT_OK,        24'd0,   5'd0}},
        '{REQ_FREE,    25'd0,        24'd0,        '{STAT_NOT_FOUND, 24'd0,   5'd0}},
        '{REQ_ALLOC,   25'd16777216, 24'd0,        '{STAT_NO_SPACE,  24'd0,   5'd0}},
        '{REQ_REALLOC, 25'd0,        24'd256,      '{STAT_OK,        24'd0,   5'd0}},
        '{REQ_ALLOC,   25'd65536,    24'd0,        '{STAT_OK,        24'd0,   5'd16}},
        '{REQ_ALLOC,   25'd1,        24'd0,        '{STAT_NO_SPACE,  24'd0,   5'd0}},
        '{REQ_REALLOC, 25'd300,      24'd0,        '{STAT_OK,        24'd0,   5'd9}},
        '{REQ_FREE,    25'd0,        24'd12345,    '{STAT_NOT_FOUND, 24'd0,   5'd0}},
        '{REQ_REALLOC, 25'd70000,    24'd0,        '{STAT_NO_SPACE,  24'd0,   5'd0}},
        '{REQ_REINIT,  25'd0,        24'd0,        '{STAT_OK,        24'd0,   5'd0}},
        '{REQ_ALLOC,   25'd255,      24'd0,        '{STAT_OK,        24'd0,   5'd8}},
        '{REQ_ALLOC,   25'd257,      24'd0,        '{STAT_OK,        24'd512, 5'd9}},
        '{REQ_REALLOC, 25'd1,        24'd16777215, '{STAT_OK,        24'd256, 5'd8}},
        '{REQ_FREE,    25'd0,        24'd512,      '{STAT_OK,        24'd0,   5'd0}},
        '{REQ_ALLOC,   25'h1FFFFFF,  24'd0,        '{STAT_NO_SPACE,  24'd0,   5'd0}},
        '{REQ_FREE,    25'd0,        24'd16777215, '{STAT_NOT_FOUND, 24'd0,   5'd0}},
        '{REQ_REINIT,  25'd0,        24'd0,        '{STAT_OK,        24'd0,   5'd0}}
    };

    // Heap and minimum block order for each random phase
    int phase_heap [NPHASE] = '{24, 8, 1, 5, 31, 12, 20};
    int phase_min  [NPHASE] = '{16, 0, 0, 24, 31, 4, 12};

    // Stimulus
    initial
    begin
        int     pick;
        grant_t none;
        none          = '0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        req_type      = '0;
        request_bytes = '0;
        block_offset  = '0;
        err_count     = 0;
        grant_count   = 0;
        tx_idle_pct   = 12;
        rx_idle_pct   = 60;
        heap_order_reg = TOTAL_ORDER_RST;
        min_order_reg  = MIN_ORDER_RST;
        heap_rebuild();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tab[r])
            send_request(dir_tab[r].req, dir_tab[r].bytes, dir_tab[r].offs, 1'b1,
                         dir_tab[r].want);
        drain();
        // Index out of range must be ignored
        write_reg(2'd2, 5'd3);
        write_reg(2'd3, 5'd31);

        for (int p = 0; p < NPHASE; p++)
        begin
            if (p == 2)
            begin
                tx_idle_pct = 60;
                rx_idle_pct = 12;
            end
            else if (p == 4)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            drain();
            write_reg(CFG_TOTAL_ORDER, phase_heap[p][4:0]);
            write_reg(CFG_MIN_ORDER, phase_min[p][4:0]);
            send_request(REQ_REINIT, SIZE_W'($urandom), OFFS_W'($urandom), 1'b0, none);
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    send_request(REQ_ALLOC, rand_size(), OFFS_W'($urandom), 1'b0, none);
                else if (pick < 78)
                    send_request(REQ_FREE, SIZE_W'($urandom),
                                 ($urandom_range(0, 9) == 0) ? OFFS_W'($urandom)
                                                             : pick_used_offset(),
                                 1'b0, none);
                else if (pick < 96)
                    send_request(REQ_REALLOC, rand_size(),
                                 ($urandom_range(0, 5) == 0) ? OFFS_W'($urandom)
                                                             : pick_used_offset(),
                                 1'b0, none);
                else
                    send_request(REQ_REINIT, SIZE_W'($urandom), OFFS_W'($urandom),
                                 1'b0, none);
                if (n == RAND_PER_PHASE / 2)
                    drain();
            end
        end
        drain();

        $display("Covered %0d result transfers: directed table plus %0d random phases",
                 grant_count, NPHASE);
        $display("Heap orders 1..31 (clamped), minimum orders 0..31, with sender/receiver stalls");
        if (err_count == 0 && grant_q.size() == 0)
            $display("buddy_block_allocator verification clean");
        else
            $display("buddy_block_allocator verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #200_000_000;
        $display("buddy_block_allocator verification failed");
        $finish;
    end

endmodule
